[sv/ttt_pkg.sv]
// Shared types and constants for the two-tier transposition table.
`default_nettype none
package ttt_pkg;

	localparam int unsigned TT_ENTRIES = 4096;
	localparam logic [22:0] MATE_THRESH_RST = 23'd900000;

	typedef enum logic {
		OP_STORE = 1'b0,
		OP_PROBE = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		BT_EXACT = 2'd0,
		BT_UPPER = 2'd1,
		BT_LOWER = 2'd2,
		BT_OTHER = 2'd3
	} bound_t;

	typedef enum logic [2:0] {
		PR_NONE  = 3'd0,
		PR_EXACT = 3'd1,
		PR_UPPER = 3'd2,
		PR_LOWER = 3'd3,
		PR_NULL  = 3'd4
	} probe_res_t;

	typedef struct packed {
		logic [63:0]        key;
		logic               valid;
		bound_t             tag;
		logic [7:0]         depth;
		logic signed [23:0] score;
		logic [31:0]        move;
	} entry_t;

	typedef struct packed {
		probe_res_t         res;
		logic signed [23:0] alpha;
		logic signed [23:0] beta;
		logic               null_fail;
	} chk_t;

endpackage
`default_nettype wire

[sv/ttt_ram.sv]
// Single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none
module ttt_ram #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned WIDTH = 8,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

[sv/ttt_check.sv]
// Bound check of one table entry against a probe request.
`default_nettype none
module ttt_check
	import ttt_pkg::*;
(
	input  wire entry_t             ent,
	input  wire logic               hit,
	input  wire logic [22:0]        mate_thresh,
	input  wire logic [7:0]         ply,
	input  wire logic [7:0]         depth,
	input  wire logic signed [8:0]  null_depth,
	input  wire logic signed [23:0] alpha,
	input  wire logic signed [23:0] beta,
	output chk_t                    chk
);

	logic signed [24:0] s25;
	logic signed [24:0] nm25;
	logic signed [24:0] ply25;
	logic signed [24:0] adj25;
	logic               d_ge_nd;

	always_comb begin
		s25     = {ent.score[23], ent.score};
		nm25    = {2'b00, mate_thresh};
		ply25   = {17'd0, ply};
		d_ge_nd = $signed({2'b00, ent.depth}) >= $signed({null_depth[8], null_depth});
		if (s25 > nm25) begin
			adj25 = s25 - ply25;
		end else if (s25 < -nm25) begin
			adj25 = s25 + ply25;
		end else begin
			adj25 = s25;
		end

		chk.res       = PR_NONE;
		chk.alpha     = alpha;
		chk.beta      = beta;
		chk.null_fail = 1'b0;
		if (hit) begin
			chk.null_fail = (ent.tag == BT_UPPER) && d_ge_nd && (ent.score < beta);
			if (ent.depth >= depth) begin
				case (ent.tag)
					BT_EXACT: begin
						chk.res   = PR_EXACT;
						chk.alpha = adj25[23:0];
					end
					BT_UPPER: begin
						if (ent.score <= alpha) begin
							chk.res   = PR_UPPER;
							chk.alpha = ent.score;
						end
					end
					BT_LOWER: begin
						if (ent.score >= beta) begin
							chk.res  = PR_LOWER;
							chk.beta = ent.score;
						end
					end
					default: ;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

[sv/two_tier_transposition_table.sv]
// Top level of the two-tier transposition table.
`default_nettype none
// Search-result cache with a depth-preferred primary table and an always-replace
// secondary table, each TABLE_ENTRIES deep and indexed by the low bits of the
// side-adjusted key. One store or probe request is taken per clock while in_stall
// is low: the tables are read at the accepting edge and the store is committed
// at the next edge, with write forwarding so back-to-back requests to the same
// index see the latest entry. A probe result passes from the s1 registers into
// the output register once s1 may advance; a stalled result holds only the
// following probe. After reset a clearing pass over every index zeroes both
// tables while in_stall is high; configuration writes are taken throughout.
module two_tier_transposition_table
	import ttt_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = TT_ENTRIES
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [22:0]        cfg_wr_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               opcode,
	input  wire logic [63:0]        position_key,
	input  wire logic               side_is_black,
	input  wire logic signed [23:0] score,
	input  wire logic [7:0]         ply,
	input  wire logic [7:0]         depth,
	input  wire logic signed [8:0]  null_depth,
	input  wire logic [1:0]         bound_tag,
	input  wire logic [31:0]        move_code,
	input  wire logic signed [23:0] alpha_in,
	input  wire logic signed [23:0] beta_in,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              probe_result,
	output logic signed [23:0]      alpha_out,
	output logic signed [23:0]      beta_out,
	output logic [31:0]             hit_move
);

	localparam int unsigned AW = $clog2(TABLE_ENTRIES);
	localparam int unsigned EW = $bits(entry_t);

	logic [22:0]        mate_thresh_q;
	logic [AW:0]        clr_q;
	logic               clearing;

	logic               accept;
	logic [63:0]        key_in;
	logic [AW-1:0]      idx_in;
	bound_t             tag_in;
	logic signed [25:0] s26;
	logic signed [25:0] nm26;
	logic signed [25:0] ply26;
	logic signed [25:0] cl26;
	logic signed [23:0] score_cl;

	logic               valid_s1;
	opcode_t            op_s1;
	logic [63:0]        key_s1;
	logic [AW-1:0]      idx_s1;
	logic signed [23:0] score_s1;
	logic [7:0]         ply_s1;
	logic [7:0]         depth_s1;
	logic signed [8:0]  nd_s1;
	bound_t             tag_s1;
	logic [31:0]        move_s1;
	logic signed [23:0] alpha_s1;
	logic signed [23:0] beta_s1;

	logic               fwd_p_q;
	logic               fwd_s_q;
	entry_t             fwd_p_data_q;
	entry_t             fwd_s_data_q;

	logic [EW-1:0]      p_rd;
	logic [EW-1:0]      s_rd;
	entry_t             p_ent;
	entry_t             s_ent;
	entry_t             new_ent;

	logic               s1_adv;
	logic               store_go;
	logic               probe_go;
	logic               replace;
	logic               p_we;
	logic               s_we;
	entry_t             p_wdata;
	entry_t             s_wdata;
	logic               ram_p_we;
	logic               ram_s_we;
	logic [AW-1:0]      ram_waddr;
	logic [EW-1:0]      ram_p_wdata;
	logic [EW-1:0]      ram_s_wdata;

	logic               p_hit;
	logic               s_hit;
	chk_t               chk_p;
	chk_t               chk_s;
	probe_res_t         res_c;
	logic signed [23:0] alpha_c;
	logic signed [23:0] beta_c;
	logic [31:0]        move_c;

	logic               out_valid_q;
	probe_res_t         res_q;
	logic signed [23:0] alpha_q;
	logic signed [23:0] beta_q;
	logic [31:0]        move_q;

	// configuration and clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mate_thresh_q <= MATE_THRESH_RST;
			clr_q         <= '0;
		end else begin
			if (cfg_wr_en) begin
				mate_thresh_q <= cfg_wr_data;
			end
			if (clearing) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	assign clearing = !clr_q[AW];

	// input side: key adjust and store score clamp
	always_comb begin
		key_in = side_is_black ? position_key : ~position_key;
		idx_in = key_in[AW-1:0];
		tag_in = bound_t'(bound_tag);
		s26    = {{2{score[23]}}, score};
		nm26   = {3'd0, mate_thresh_q};
		ply26  = {18'd0, ply};
		cl26   = s26;
		case (tag_in)
			BT_EXACT: begin
				if (s26 > nm26) begin
					cl26 = s26 + ply26;
				end else if (s26 < -nm26) begin
					cl26 = s26 - ply26;
				end
			end
			BT_UPPER: begin
				if (s26 < -nm26) begin
					cl26 = -nm26;
				end
			end
			BT_LOWER: begin
				if (s26 > nm26) begin
					cl26 = nm26;
				end
			end
			default: ;
		endcase
		if (cl26 > 26'sd8388607) begin
			score_cl = 24'sh7FFFFF;
		end else if (cl26 < -26'sd8388608) begin
			score_cl = 24'sh800000;
		end else begin
			score_cl = cl26[23:0];
		end
	end

	assign s1_adv   = !valid_s1 || (op_s1 == OP_STORE) || !out_valid_q || !out_stall;
	assign in_stall = clearing || (valid_s1 && !s1_adv);
	assign accept   = in_valid && !in_stall;
	assign store_go = valid_s1 && (op_s1 == OP_STORE);
	assign probe_go = valid_s1 && (op_s1 == OP_PROBE) && s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1        <= opcode_t'(opcode);
			key_s1       <= key_in;
			idx_s1       <= idx_in;
			score_s1     <= score_cl;
			ply_s1       <= ply;
			depth_s1     <= depth;
			nd_s1        <= null_depth;
			tag_s1       <= tag_in;
			move_s1      <= move_code;
			alpha_s1     <= alpha_in;
			beta_s1      <= beta_in;
			fwd_p_q      <= p_we && (idx_s1 == idx_in);
			fwd_s_q      <= s_we && (idx_s1 == idx_in);
			fwd_p_data_q <= p_wdata;
			fwd_s_data_q <= s_wdata;
		end
	end

	ttt_ram #(
		.DEPTH (TABLE_ENTRIES),
		.WIDTH (EW)
	) u_prim (
		.clk   (clk),
		.we    (ram_p_we),
		.waddr (ram_waddr),
		.wdata (ram_p_wdata),
		.re    (accept),
		.raddr (idx_in),
		.rdata (p_rd)
	);

	ttt_ram #(
		.DEPTH (TABLE_ENTRIES),
		.WIDTH (EW)
	) u_sec (
		.clk   (clk),
		.we    (ram_s_we),
		.waddr (ram_waddr),
		.wdata (ram_s_wdata),
		.re    (accept),
		.raddr (idx_in),
		.rdata (s_rd)
	);

	assign p_ent = fwd_p_q ? fwd_p_data_q : entry_t'(p_rd);
	assign s_ent = fwd_s_q ? fwd_s_data_q : entry_t'(s_rd);

	// store: replacement decision and write-back
	always_comb begin
		new_ent.key   = key_s1;
		new_ent.valid = 1'b1;
		new_ent.tag   = tag_s1;
		new_ent.depth = depth_s1;
		new_ent.score = score_s1;
		new_ent.move  = move_s1;
		replace = !p_ent.valid || (p_ent.key != key_s1) || (p_ent.depth < depth_s1) ||
			((p_ent.depth == depth_s1) &&
			((tag_s1 == BT_EXACT) ||
			((tag_s1 == BT_LOWER) && (p_ent.tag == BT_LOWER) && (score_s1 > p_ent.score)) ||
			((tag_s1 == BT_UPPER) && (p_ent.tag == BT_UPPER) && (score_s1 < p_ent.score))));
		p_we    = store_go && replace;
		s_we    = store_go;
		p_wdata = new_ent;
		s_wdata = replace ? p_ent : new_ent;
	end

	always_comb begin
		if (clearing) begin
			ram_p_we    = 1'b1;
			ram_s_we    = 1'b1;
			ram_waddr   = clr_q[AW-1:0];
			ram_p_wdata = '0;
			ram_s_wdata = '0;
		end else begin
			ram_p_we    = p_we;
			ram_s_we    = s_we;
			ram_waddr   = idx_s1;
			ram_p_wdata = p_wdata;
			ram_s_wdata = s_wdata;
		end
	end

	// probe
	assign p_hit = p_ent.valid && (p_ent.key == key_s1);
	assign s_hit = s_ent.valid && (s_ent.key == key_s1);

	ttt_check u_chk_p (
		.ent         (p_ent),
		.hit         (p_hit),
		.mate_thresh (mate_thresh_q),
		.ply         (ply_s1),
		.depth       (depth_s1),
		.null_depth  (nd_s1),
		.alpha       (alpha_s1),
		.beta        (beta_s1),
		.chk         (chk_p)
	);

	ttt_check u_chk_s (
		.ent         (s_ent),
		.hit         (s_hit),
		.mate_thresh (mate_thresh_q),
		.ply         (ply_s1),
		.depth       (depth_s1),
		.null_depth  (nd_s1),
		.alpha       (alpha_s1),
		.beta        (beta_s1),
		.chk         (chk_s)
	);

	always_comb begin
		if (chk_p.res != PR_NONE) begin
			res_c   = chk_p.res;
			alpha_c = chk_p.alpha;
			beta_c  = chk_p.beta;
		end else if (chk_s.res != PR_NONE) begin
			res_c   = chk_s.res;
			alpha_c = chk_s.alpha;
			beta_c  = chk_s.beta;
		end else begin
			res_c   = (chk_p.null_fail || chk_s.null_fail) ? PR_NULL : PR_NONE;
			alpha_c = alpha_s1;
			beta_c  = beta_s1;
		end
		if (p_hit) begin
			move_c = p_ent.move;
		end else if (s_hit) begin
			move_c = s_ent.move;
		end else begin
			move_c = '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (probe_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (probe_go) begin
			res_q   <= res_c;
			alpha_q <= alpha_c;
			beta_q  <= beta_c;
			move_q  <= move_c;
		end
	end

	assign out_valid    = out_valid_q;
	assign probe_result = res_q;
	assign alpha_out    = alpha_q;
	assign beta_out     = beta_q;
	assign hit_move     = move_q;

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the two-tier transposition table.
`timescale 1ns / 100ps

import ttt_pkg::*;

typedef struct {
	opcode_t            op;
	logic [63:0]        key;
	logic               black;
	logic signed [23:0] score;
	logic [7:0]         ply;
	logic [7:0]         depth;
	logic signed [8:0]  null_depth;
	bound_t             tag;
	logic [31:0]        move;
	logic signed [23:0] alpha;
	logic signed [23:0] beta;
} tt_request_t;

typedef struct {
	probe_res_t  res;
	logic [23:0] alpha;
	logic [23:0] beta;
	logic [31:0] move;
} probe_out_t;

class tt_scoreboard;
	entry_t      primary_tab[TT_ENTRIES];
	entry_t      secondary_tab[TT_ENTRIES];
	int unsigned mate_thresh;
	probe_out_t  pending[$];
	int          mismatches;

	function new();
		foreach (primary_tab[i]) begin
			primary_tab[i] = '0;
			secondary_tab[i] = '0;
		end
		mate_thresh = MATE_THRESH_RST;
		mismatches = 0;
	endfunction

	// bound test on one matching entry; PR_NONE means keep looking
	function probe_res_t examine(entry_t e, int ply, int need, int nd,
			inout int a, inout int b, inout bit nf);
		int s;
		int d;
		int nm;
		s = {{8{e.score[23]}}, e.score};
		d = e.depth;
		nm = mate_thresh;
		if (e.tag == BT_UPPER && d >= nd && s < b)
			nf = 1'b1;
		if (d < need)
			return PR_NONE;
		if (e.tag == BT_EXACT) begin
			if (s > nm)
				s = s - ply;
			else if (s < -nm)
				s = s + ply;
			a = s;
			return PR_EXACT;
		end
		if (e.tag == BT_UPPER && s <= a) begin
			a = s;
			return PR_UPPER;
		end
		if (e.tag == BT_LOWER && s >= b) begin
			b = s;
			return PR_LOWER;
		end
		return PR_NONE;
	endfunction

	function void note_request(tt_request_t r);
		logic [63:0] k;
		int          idx;
		int          s;
		int          ps;
		int          nm;
		int          ply;
		int          nd;
		int          a;
		int          b;
		bit          nf;
		bit          repl;
		bit          p_hit;
		bit          s_hit;
		entry_t      pe;
		entry_t      ne;
		probe_out_t  o;
		k = r.black ? r.key : ~r.key;
		idx = int'(k % TT_ENTRIES);
		s = {{8{r.score[23]}}, r.score};
		nm = mate_thresh;
		ply = r.ply;
		if (r.op == OP_STORE) begin
			pe = primary_tab[idx];
			ps = {{8{pe.score[23]}}, pe.score};
			case (r.tag)
				BT_EXACT: begin
					if (s > nm)
						s = s + ply;
					else if (s < -nm)
						s = s - ply;
				end
				BT_UPPER: if (s < -nm) s = -nm;
				BT_LOWER: if (s > nm) s = nm;
				default: ;
			endcase
			if (s > 8388607)
				s = 8388607;
			if (s < -8388608)
				s = -8388608;
			repl = !pe.valid || pe.key != k || pe.depth < r.depth ||
				(pe.depth == r.depth && (r.tag == BT_EXACT ||
				(r.tag == BT_LOWER && pe.tag == BT_LOWER && s > ps) ||
				(r.tag == BT_UPPER && pe.tag == BT_UPPER && s < ps)));
			ne.key = k;
			ne.valid = 1'b1;
			ne.tag = r.tag;
			ne.depth = r.depth;
			ne.score = s[23:0];
			ne.move = r.move;
			if (repl) begin
				secondary_tab[idx] = pe;
				primary_tab[idx] = ne;
			end else begin
				secondary_tab[idx] = ne;
			end
		end else begin
			p_hit = primary_tab[idx].valid && primary_tab[idx].key == k;
			s_hit = secondary_tab[idx].valid && secondary_tab[idx].key == k;
			a = {{8{r.alpha[23]}}, r.alpha};
			b = {{8{r.beta[23]}}, r.beta};
			nd = {{23{r.null_depth[8]}}, r.null_depth};
			nf = 1'b0;
			o.res = PR_NONE;
			if (p_hit)
				o.res = examine(primary_tab[idx], ply, r.depth, nd, a, b, nf);
			if (o.res == PR_NONE && s_hit)
				o.res = examine(secondary_tab[idx], ply, r.depth, nd, a, b, nf);
			if (o.res == PR_NONE && nf)
				o.res = PR_NULL;
			o.alpha = a[23:0];
			o.beta = b[23:0];
			o.move = p_hit ? primary_tab[idx].move : (s_hit ? secondary_tab[idx].move : '0);
			pending.push_back(o);
		end
	endfunction

	function void field_check(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function void check_probe(logic [2:0] res, logic [23:0] a, logic [23:0] b, logic [31:0] mv);
		probe_out_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual %0d/%h/%h/%h",
				$time, res, a, b, mv);
			mismatches++;
			return;
		end
		e = pending.pop_front();
		field_check("probe_result", e.res, res);
		field_check("alpha_out", e.alpha, a);
		field_check("beta_out", e.beta, b);
		field_check("hit_move", e.move, mv);
	endfunction
endclass

module testbench;
	localparam int CYCLE_LIMIT = 250000;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [22:0]        cfg_wr_data;
	logic               in_valid;
	logic               in_stall;
	logic               opcode;
	logic [63:0]        position_key;
	logic               side_is_black;
	logic signed [23:0] score;
	logic [7:0]         ply;
	logic [7:0]         depth;
	logic signed [8:0]  null_depth;
	logic [1:0]         bound_tag;
	logic [31:0]        move_code;
	logic signed [23:0] alpha_in;
	logic signed [23:0] beta_in;
	logic               out_valid;
	logic               out_stall;
	logic [2:0]         probe_result;
	logic signed [23:0] alpha_out;
	logic signed [23:0] beta_out;
	logic [31:0]        hit_move;

	tt_scoreboard sb = new();
	bit           sender_idle;
	bit           receiver_idle;
	int           cycles;
	logic [63:0]  key_pool[24];

	two_tier_transposition_table u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.position_key(position_key),
		.side_is_black(side_is_black),
		.score(score),
		.ply(ply),
		.depth(depth),
		.null_depth(null_depth),
		.bound_tag(bound_tag),
		.move_code(move_code),
		.alpha_in(alpha_in),
		.beta_in(beta_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.probe_result(probe_result),
		.alpha_out(alpha_out),
		.beta_out(beta_out),
		.hit_move(hit_move)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** two_tier_transposition_table: FAILED **");
			$finish;
		end
	end

	// result side: random back-pressure after each accepted result while receiver_idle is set
	initial begin
		int hold;
		hold = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && !out_stall) begin
				sb.check_probe(probe_result, alpha_out, beta_out, hit_move);
				hold = receiver_idle ? $urandom_range(0, 7) : 0;
			end else if (hold > 0) begin
				hold--;
			end
			out_stall <= (hold > 0);
		end
	end

	function automatic logic signed [23:0] pick_score();
		int nm;
		nm = sb.mate_thresh;
		case ($urandom_range(0, 5))
			0: return 24'($urandom);
			1: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
			2: return 24'(nm + $urandom_range(0, 6) - 3);
			3: return 24'(-nm + $urandom_range(0, 6) - 3);
			default: return 24'($urandom_range(0, 2000) - 1000);
		endcase
	endfunction

	// keys given here are side-adjusted; the side bit is drawn and the port key derived
	function automatic tt_request_t store_req(logic [63:0] ek, logic signed [23:0] sc,
			logic [7:0] pl, logic [7:0] dp, bound_t tg, logic [31:0] mv);
		tt_request_t r;
		r.op = OP_STORE;
		r.black = 1'($urandom_range(0, 1));
		r.key = r.black ? ek : ~ek;
		r.score = sc;
		r.ply = pl;
		r.depth = dp;
		r.tag = tg;
		r.move = mv;
		r.null_depth = 9'($urandom);
		r.alpha = 24'($urandom);
		r.beta = 24'($urandom);
		return r;
	endfunction

	function automatic tt_request_t probe_req(logic [63:0] ek, logic [7:0] pl, logic [7:0] dp,
			logic signed [8:0] nd, logic signed [23:0] al, logic signed [23:0] be);
		tt_request_t r;
		r.op = OP_PROBE;
		r.black = 1'($urandom_range(0, 1));
		r.key = r.black ? ek : ~ek;
		r.ply = pl;
		r.depth = dp;
		r.null_depth = nd;
		r.alpha = al;
		r.beta = be;
		r.score = 24'($urandom);
		r.tag = bound_t'($urandom_range(0, 3));
		r.move = $urandom;
		return r;
	endfunction

	function automatic tt_request_t random_request();
		logic [63:0]       ek;
		logic [7:0]        dp;
		logic signed [8:0] nd;
		ek = ($urandom_range(0, 6) == 0) ? {$urandom, $urandom} : key_pool[$urandom_range(0, 23)];
		dp = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 12));
		nd = $urandom_range(0, 1) ? 9'($urandom_range(0, 510) - 255) :
			9'(dp - $urandom_range(0, 3));
		if ($urandom_range(0, 1))
			return store_req(ek, pick_score(), 8'($urandom_range(0, 255)), dp,
				bound_t'($urandom_range(0, 3)), $urandom);
		return probe_req(ek, 8'($urandom_range(0, 255)), dp, nd, pick_score(), pick_score());
	endfunction

	task automatic send_request(tt_request_t r);
		int gap;
		gap = sender_idle ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= r.op;
		position_key <= r.key;
		side_is_black <= r.black;
		score <= r.score;
		ply <= r.ply;
		depth <= r.depth;
		null_depth <= r.null_depth;
		bound_tag <= r.tag;
		move_code <= r.move;
		alpha_in <= r.alpha;
		beta_in <= r.beta;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(r);
	endtask

	// drop valid and let pending probes and the last store retire
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_mate_thresh(logic [22:0] val);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= val;
		@(posedge clk);
		sb.mate_thresh = val;
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		logic [11:0] slots[6];
		int unsigned nm_list[6];
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		in_valid <= 1'b0;
		opcode <= OP_STORE;
		position_key <= '0;
		side_is_black <= 1'b0;
		score <= '0;
		ply <= '0;
		depth <= '0;
		null_depth <= '0;
		bound_tag <= BT_EXACT;
		move_code <= '0;
		alpha_in <= '0;
		beta_in <= '0;
		sender_idle = 1'b1;
		receiver_idle = 1'b1;

		slots = '{12'h000, 12'hFFF, 12'h007, 12'(TT_ENTRIES / 2), 12'($urandom),
			12'($urandom)};
		foreach (key_pool[i]) begin
			key_pool[i] = {$urandom, $urandom};
			key_pool[i][11:0] = slots[i % 6];
		end
		key_pool[0] = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed requests at the reset value of the mate threshold
		send_request(probe_req(64'h0, 8'd0, 8'd0, 9'sd0, 24'sd0, 24'sd0));
		send_request(store_req(64'hFFFF_FFFF_FFFF_FFFF, 24'sh7FFFFF, 8'd255, 8'd255,
			BT_EXACT, 32'hFFFF_FFFF));
		send_request(probe_req(64'hFFFF_FFFF_FFFF_FFFF, 8'd255, 8'd255, 9'sd255,
			24'sh800000, 24'sh7FFFFF));
		send_request(store_req(64'h0000_0000_0000_1001, 24'sh800000, 8'd255, 8'd0,
			BT_EXACT, 32'h0));
		send_request(probe_req(64'h0000_0000_0000_1001, 8'd255, 8'd0, -9'sd255, 24'sd0, 24'sd0));
		send_request(store_req(64'h1234_5678_9ABC_D002, 24'sh7FFFFF, 8'd0, 8'd10,
			BT_LOWER, 32'h1));
		send_request(probe_req(64'h1234_5678_9ABC_D002, 8'd0, 8'd10, 9'sd0,
			24'sh800000, 24'sh800000));
		send_request(store_req(64'h8765_4321_0FED_C003, 24'sh800000, 8'd7, 8'd5,
			BT_UPPER, 32'h8000_0000));
		send_request(probe_req(64'h8765_4321_0FED_C003, 8'd0, 8'd5, 9'sd0,
			24'sh7FFFFF, 24'sh7FFFFF));
		send_request(probe_req(64'h8765_4321_0FED_C003, 8'd0, 8'd6, 9'sd5, 24'sd0, 24'sd0));
		send_request(store_req(64'h5555_AAAA_5555_A004, 24'sd123, 8'd0, 8'd20,
			BT_OTHER, 32'h1111_1111));
		send_request(probe_req(64'h5555_AAAA_5555_A004, 8'd0, 8'd0, 9'sd0, -24'sd100, 24'sd100));
		send_request(store_req(64'h5555_AAAA_5555_A004, 24'sd50, 8'd0, 8'd20,
			BT_OTHER, 32'h2222_2222));
		send_request(store_req(64'h0000_FFFF_0000_0004, 24'sd7, 8'd0, 8'd1,
			BT_EXACT, 32'h3333_3333));
		send_request(probe_req(64'h5555_AAAA_5555_A004, 8'd0, 8'd0, 9'sd0, 24'sd0, 24'sd0));
		send_request(store_req(64'h0F0F_0F0F_0F0F_0005, 24'sd100, 8'd0, 8'd4, BT_LOWER, 32'hA));
		send_request(store_req(64'h0F0F_0F0F_0F0F_0005, 24'sd200, 8'd0, 8'd4, BT_LOWER, 32'hB));
		send_request(store_req(64'h0F0F_0F0F_0F0F_0005, 24'sd150, 8'd0, 8'd3, BT_UPPER, 32'hC));
		send_request(probe_req(64'h0F0F_0F0F_0F0F_0005, 8'd0, 8'd4, 9'sd0, 24'sd0, 24'sd150));
		send_request(store_req(64'h7777_0000_1111_0006, 24'sd40, 8'd0, 8'd6, BT_UPPER, 32'hD));
		send_request(store_req(64'h7777_0000_1111_0006, 24'sd30, 8'd0, 8'd6, BT_UPPER, 32'hE));
		send_request(probe_req(64'h7777_0000_1111_0006, 8'd0, 8'd9, 9'sd255, 24'sd35, 24'sd35));
		send_request(probe_req(64'h7777_0000_1111_0006, 8'd3, 8'd6, -9'sd255, 24'sd35, 24'sd35));
		send_request(store_req(64'h7777_0000_1111_0006, -24'sd950000, 8'd9, 8'd6,
			BT_EXACT, 32'hF));
		send_request(probe_req(64'h7777_0000_1111_0006, 8'd9, 8'd0, 9'sd0, 24'sd0, 24'sd0));

		nm_list = '{0, 8388607, 1000, $urandom_range(1, 8388606), 900000, 255};
		foreach (nm_list[p]) begin
			settle();
			write_mate_thresh(23'(nm_list[p]));
			sender_idle = $urandom_range(0, 3) != 0;
			receiver_idle = $urandom_range(0, 3) != 0;
			repeat (320) begin
				if ($urandom_range(0, 63) == 0)
					sender_idle = !sender_idle;
				if ($urandom_range(0, 63) == 0)
					receiver_idle = !receiver_idle;
				send_request(random_request());
			end
		end

		settle();
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("** two_tier_transposition_table: PASSED **");
		else
			$display("** two_tier_transposition_table: FAILED **");
		$finish;
	end
endmodule

[files.f]
sv/ttt_pkg.sv
sv/ttt_ram.sv
sv/ttt_check.sv
sv/two_tier_transposition_table.sv
tb/sv/testbench.sv
